### src/fibc_pkg.sv
// Shared types and constants for the fault injection backoff controller.
package fibc_pkg;

  // Field widths
  localparam int unsigned NOW_W     = 31;
  localparam int unsigned LEVEL_W   = 15;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned SEED_W    = 32;
  localparam int unsigned BACKOFF_W = 16;
  localparam int unsigned TOTAL_W   = 20;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BACKOFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF = 3'd4;

  // Reset values
  localparam logic [LEVEL_W-1:0]   FAIL_LEVEL_RST  = 15'd0;
  localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST = 4'd3;
  localparam logic [BACKOFF_W-1:0] MIN_BACKOFF_RST = 16'd100;
  localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST = 16'd5000;

  // Generator and policy constants
  localparam logic [31:0] LCG_MUL        = 32'd1103515245;
  localparam logic [31:0] LCG_INC        = 32'd12345;
  localparam logic [31:0] RECENT_SECONDS = 32'd10;
  localparam int unsigned RAISE_COUNT    = 5;
  localparam int unsigned RETRY_LIMIT    = 15;
  // ceil(2^17 / 3): exact quotient by three for any 17-bit dividend
  localparam logic [16:0] DIV3_RECIP     = 17'd43691;

  typedef struct packed {
    logic accept;    // latch a new attempt
    logic draw;      // advance the generator
    logic log_fail;  // mark failure and store the timestamp
    logic scan;      // walk the timestamp ring
    logic adapt;     // update the adaptive base
    logic add;       // add one retry backoff and draw
    logic set_ok;    // mark success
    logic emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic inj_en;
    logic fails;
    logic scan_done;
    logic retry_done;
    logic out_free;
  } sts_t;

endpackage

### src/fault_injection_backoff_controller_top.sv
// Top level of the fault injection backoff controller.
//
// Each transaction on the s_axis channel is one operation attempt; tdata carries
// the current time in seconds. The block decides whether the attempt fails,
// logs failures in a timestamp ring, adapts the backoff base and draws up to
// the configured number of retries, then returns one result transaction on m_axis.
// Settings are written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
// a seed write reloads the random generator.
// With injection off an attempt goes straight to the result; a failure is followed
// by a scan of the timestamp ring (at most WINDOW_DEPTH entries, one registered RAM
// read per cycle), the base update and the retry draws. One attempt is processed
// at a time; the next is taken once the result is in the output register. If the
// receiver stalls, the result holds in that register while the next attempt is
// accepted and worked on; its result waits for the slot.
// Reset clears the generator, the ring pointers and the output register, and
// sets the base to 100 ms; the ring contents are not cleared.
module fault_injection_backoff_controller_top
  import fibc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [30:0] now_sec
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] failed, [1] succeeded, [5:2] retries_made, [25:6] backoff_sum_ms,
  // [41:26] adaptive_base_ms
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  fibc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fibc_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .now_i       (s_axis_tdata[NOW_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### src/fibc_ram.sv
// Generic single write port RAM with registered read.
module fibc_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/fibc_ctrl.sv
// Sequencing state machine for one attempt.
module fibc_ctrl
  import fibc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAW  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_ADAPT = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_RCHK  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.inj_en ? S_DRAW : S_EMIT;
        end
      end
      S_DRAW: begin
        cmd_o.draw = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.fails) begin
          cmd_o.log_fail = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_ADAPT;
        end
      end
      S_ADAPT: begin
        cmd_o.adapt = 1'b1;
        state_d     = S_ADD;
      end
      S_ADD: begin
        if (sts_i.retry_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.add = 1'b1;
          state_d   = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!sts_i.fails) begin
          cmd_o.set_ok = 1'b1;
          state_d      = S_EMIT;
        end else begin
          state_d = S_ADD;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/fibc_dp.sv
// Datapath: settings, generator, timestamp ring, adaptive base, retry sum, output register.
module fibc_dp
  import fibc_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [NOW_W-1:0]      now_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned IDX_W  = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  // Settings
  logic [LEVEL_W-1:0]   fail_level_q;
  logic [RETRY_W-1:0]   retry_max_q;
  logic [BACKOFF_W-1:0] min_q, max_q;

  // Working state
  logic [SEED_W-1:0]    rng_q;
  logic [IDX_W-1:0]     head_q;
  logic [FILL_W-1:0]    fill_q;
  logic [FILL_W-1:0]    scan_idx_q;
  logic [FILL_W-1:0]    recent_q;
  logic                 rd_pend_q;
  logic [BACKOFF_W-1:0] base_q;
  logic [NOW_W-1:0]     now_q;
  logic                 failed_q, success_q;
  logic [RETRY_W-1:0]   retries_q;
  logic [TOTAL_W-1:0]   total_q;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [NOW_W-1:0]     rd_data;
  logic                 rd_en;
  logic [LEVEL_W-1:0]   roll;
  logic [RETRY_W-1:0]   limit;
  logic                 is_recent;
  logic [17:0]          up_sum;
  logic [16:0]          up_val;
  logic [BACKOFF_W-1:0] up_base;
  logic [33:0]          dn_prod;
  logic [16:0]          dn_val;
  logic [BACKOFF_W-1:0] dn_base;
  logic [30:0]          shifted;
  logic [BACKOFF_W-1:0] backoff;
  logic [TOTAL_W:0]     sum;
  logic [31:0]          rng_next;

  assign roll     = rng_q[30:16];
  assign rng_next = rng_q * LCG_MUL + LCG_INC;
  assign limit    = ({1'b0, retry_max_q} < 5'(RETRY_LIMIT)) ? retry_max_q
                                                             : RETRY_W'(RETRY_LIMIT);

  assign rd_en = cmd_i.scan && (scan_idx_q < fill_q);

  fibc_ram #(
    .WIDTH (NOW_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.log_fail),
    .waddr_i (head_q),
    .wdata_i (now_q),
    .re_i    (rd_en),
    .raddr_i (scan_idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  // A stored time later than now counts as recent, no wrap on the addition
  assign is_recent = ({1'b0, rd_data} + RECENT_SECONDS) >= {1'b0, now_q};

  // Raise by 3/2, cap at max
  assign up_sum  = {2'b00, base_q} + {1'b0, base_q, 1'b0};
  assign up_val  = up_sum[17:1];
  assign up_base = (up_val > {1'b0, max_q}) ? max_q : up_val[15:0];

  // Lower by 2/3 through the reciprocal, floor at min
  assign dn_prod = {base_q, 1'b0} * DIV3_RECIP;
  assign dn_val  = dn_prod[33:17];
  assign dn_base = (dn_val < {1'b0, min_q}) ? min_q : dn_val[15:0];

  // Retry backoff: base << k saturated at max, sum saturated at the field width
  assign shifted = 31'(base_q) << retries_q;
  assign backoff = (shifted > 31'(max_q)) ? max_q : shifted[15:0];
  assign sum     = {1'b0, total_q} + (TOTAL_W + 1)'(backoff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_level_q  <= FAIL_LEVEL_RST;
      retry_max_q   <= MAX_RETRIES_RST;
      min_q         <= MIN_BACKOFF_RST;
      max_q         <= MAX_BACKOFF_RST;
      rng_q         <= '0;
      head_q        <= '0;
      fill_q        <= '0;
      scan_idx_q    <= '0;
      recent_q      <= '0;
      rd_pend_q     <= 1'b0;
      base_q        <= MIN_BACKOFF_RST;
      failed_q      <= 1'b0;
      success_q     <= 1'b1;
      retries_q     <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FAIL_LEVEL:  fail_level_q  <= cfg_data_i[LEVEL_W-1:0];
          CFG_MAX_RETRIES: retry_max_q   <= cfg_data_i[RETRY_W-1:0];
          CFG_SEED_VALUE:  rng_q         <= cfg_data_i[SEED_W-1:0];
          CFG_MIN_BACKOFF: min_q         <= cfg_data_i[BACKOFF_W-1:0];
          CFG_MAX_BACKOFF: max_q         <= cfg_data_i[BACKOFF_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.accept) begin
        failed_q  <= 1'b0;
        success_q <= 1'b1;
        retries_q <= '0;
        total_q   <= '0;
      end

      if (cmd_i.draw || cmd_i.add) begin
        rng_q <= rng_next;
      end

      if (cmd_i.log_fail) begin
        failed_q   <= 1'b1;
        success_q  <= 1'b0;
        head_q     <= (head_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
        if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        scan_idx_q <= '0;
        recent_q   <= '0;
        rd_pend_q  <= 1'b0;
      end

      if (cmd_i.scan) begin
        if (rd_en) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        rd_pend_q <= rd_en;
        if (rd_pend_q && is_recent) begin
          recent_q <= recent_q + 1'b1;
        end
      end

      if (cmd_i.adapt) begin
        if (32'(recent_q) >= RAISE_COUNT) begin
          base_q <= up_base;
        end else if (32'(recent_q) <= 32'd1) begin
          base_q <= dn_base;
        end
      end

      if (cmd_i.add) begin
        total_q   <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        retries_q <= retries_q + 1'b1;
      end

      if (cmd_i.set_ok) begin
        success_q <= 1'b1;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      now_q <= now_i;
    end
    if (cmd_i.emit) begin
      out_data_q <= {6'b0, base_q, total_q, retries_q, success_q, failed_q};
    end
  end

  assign sts_o.inj_en     = (fail_level_q != '0);
  assign sts_o.fails      = (roll < fail_level_q);
  assign sts_o.scan_done  = (scan_idx_q == fill_q) && !rd_pend_q;
  assign sts_o.retry_done = (retries_q == limit);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### verif/fault_injection_backoff_controller_top_tb.sv
// Self-checking testbench for the fault injection backoff controller top level.
module fault_injection_backoff_controller_top_tb;
  import fibc_pkg::*;

  localparam int unsigned WINDOW_DEPTH   = 16;
  localparam int unsigned TOTAL_CEILING  = (1 << TOTAL_W) - 1;
  localparam int unsigned LATENCY_MARGIN = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 600;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned DIRECTED_ROWS  = 24;

  typedef struct packed {
    logic                 failed;
    logic                 succeeded;
    logic [RETRY_W-1:0]   retries_made;
    logic [TOTAL_W-1:0]   backoff_sum_ms;
    logic [BACKOFF_W-1:0] adaptive_base_ms;
  } attempt_outcome_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   fail_level;
    logic [RETRY_W-1:0]   retry_max;
    logic [SEED_W-1:0]    seed_value;
    logic [BACKOFF_W-1:0] min_backoff_ms;
    logic [BACKOFF_W-1:0] max_backoff_ms;
  } backoff_settings_t;

  typedef struct packed {
    logic [2:0]       setting;
    logic [NOW_W-1:0] now_sec;
    logic             known;
    attempt_outcome_t outcome;
  } directed_row_t;

  localparam attempt_outcome_t IDLE_OUTCOME = '{1'b0, 1'b1, 4'd0, 20'd0, MIN_BACKOFF_RST};
  localparam attempt_outcome_t NO_OUTCOME   = '0;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [30:0] now_sec
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] failed, [1] succeeded, [5:2] retries_made, [25:6] backoff_sum_ms,
  // [41:26] adaptive_base_ms
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_FAIL_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predicted block state
  logic [LEVEL_W-1:0]   cfg_fail_level  = FAIL_LEVEL_RST;
  logic [RETRY_W-1:0]   cfg_retry_max   = MAX_RETRIES_RST;
  logic [BACKOFF_W-1:0] cfg_min_ms      = MIN_BACKOFF_RST;
  logic [BACKOFF_W-1:0] cfg_max_ms      = MAX_BACKOFF_RST;
  logic [31:0]          lcg_state       = '0;
  logic [NOW_W-1:0]     fault_stamps [WINDOW_DEPTH];
  int unsigned          stamp_head      = 0;
  int unsigned          stamp_count     = 0;
  logic [BACKOFF_W-1:0] backoff_base_ms = MIN_BACKOFF_RST;

  attempt_outcome_t pending_outcomes [$];
  int unsigned      mismatch_count = 0;
  bit               feed_steady    = 1'b0;
  bit               sink_steady    = 1'b0;
  int unsigned      sink_hold      = 0;

  backoff_settings_t directed_settings [5] = '{
    '{FAIL_LEVEL_RST, MAX_RETRIES_RST, 32'h0000_0000, MIN_BACKOFF_RST, MAX_BACKOFF_RST},
    '{15'h7FFF, 4'd15, 32'hFFFF_FFFF, 16'd1,     16'hFFFF},
    '{15'h7FFF, 4'd0,  32'h1234_5678, 16'hFFFF,  16'd1},
    '{15'd1,    4'd15, 32'h0000_0000, 16'd100,   16'd5000},
    '{15'h7FFF, 4'd2,  32'hA5A5_A5A5, 16'd0,     16'hFFFF}
  };

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // injection off after reset: base untouched, nothing drawn
    '{3'd0, 31'd0,          1'b1, IDLE_OUTCOME},
    '{3'd0, 31'h7FFF_FFFF,  1'b1, IDLE_OUTCOME},
    '{3'd0, 31'h2AAA_AAAA,  1'b1, IDLE_OUTCOME},
    '{3'd0, 31'h5555_5555,  1'b1, IDLE_OUTCOME},
    // near-certain failure, full retries: burst near time zero raises the base
    '{3'd1, 31'd0,          1'b0, NO_OUTCOME},
    '{3'd1, 31'd0,          1'b0, NO_OUTCOME},
    '{3'd1, 31'd3,          1'b0, NO_OUTCOME},
    '{3'd1, 31'd7,          1'b0, NO_OUTCOME},
    '{3'd1, 31'd10,         1'b0, NO_OUTCOME},
    '{3'd1, 31'd10,         1'b0, NO_OUTCOME},
    '{3'd1, 31'd11,         1'b0, NO_OUTCOME},
    '{3'd1, 31'd200,        1'b0, NO_OUTCOME},
    '{3'd1, 31'd500,        1'b0, NO_OUTCOME},
    // time going backwards: later stamps still count as recent
    '{3'd1, 31'd5,          1'b0, NO_OUTCOME},
    // floor above cap, no retries: lowering floors high, raising caps low
    '{3'd2, 31'h7FFF_FFFF,  1'b0, NO_OUTCOME},
    '{3'd2, 31'h7FFF_FFFF,  1'b0, NO_OUTCOME},
    '{3'd2, 31'h7FFF_FFFF,  1'b0, NO_OUTCOME},
    '{3'd2, 31'h7FFF_FFFF,  1'b0, NO_OUTCOME},
    '{3'd2, 31'h7FFF_FFFF,  1'b0, NO_OUTCOME},
    // smallest nonzero level
    '{3'd3, 31'h7FFF_FFF6,  1'b0, NO_OUTCOME},
    '{3'd3, 31'h4000_0000,  1'b0, NO_OUTCOME},
    // zero floor: sparse failures, ring wraps
    '{3'd4, 31'd1000,       1'b0, NO_OUTCOME},
    '{3'd4, 31'd3000,       1'b0, NO_OUTCOME},
    '{3'd4, 31'd6000,       1'b0, NO_OUTCOME}
  };

  fault_injection_backoff_controller_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit next_draw_fails();
    lcg_state = lcg_state * LCG_MUL + LCG_INC;
    return lcg_state[30:16] < cfg_fail_level;
  endfunction

  function automatic attempt_outcome_t predict_attempt(input logic [NOW_W-1:0] now_s);
    attempt_outcome_t res;
    int unsigned      recent;
    int unsigned      b;
    int unsigned      limit;
    int unsigned      total;
    longint unsigned  step;
    res = '{1'b0, 1'b1, 4'd0, 20'd0, 16'd0};
    if (cfg_fail_level != '0 && next_draw_fails()) begin
      res.failed    = 1'b1;
      res.succeeded = 1'b0;
      fault_stamps[stamp_head] = now_s;
      stamp_head = (stamp_head + 1) % WINDOW_DEPTH;
      if (stamp_count < WINDOW_DEPTH) stamp_count++;
      recent = 0;
      // no wrap: a stamp later than now counts as recent
      for (int i = 0; i < int'(stamp_count); i++) begin
        if (32'(fault_stamps[i]) + RECENT_SECONDS >= 32'(now_s)) recent++;
      end
      b = 32'(backoff_base_ms);
      if (recent >= RAISE_COUNT) begin
        b = b * 3 / 2;
        if (b > 32'(cfg_max_ms)) b = 32'(cfg_max_ms);
        backoff_base_ms = b[BACKOFF_W-1:0];
      end else if (recent <= 1) begin
        b = b * 2 / 3;
        if (b < 32'(cfg_min_ms)) b = 32'(cfg_min_ms);
        backoff_base_ms = b[BACKOFF_W-1:0];
      end
      limit = (32'(cfg_retry_max) < RETRY_LIMIT) ? 32'(cfg_retry_max) : RETRY_LIMIT;
      total = 0;
      for (int k = 0; k < int'(limit); k++) begin
        step = 64'(backoff_base_ms) << k;
        if (step > 64'(cfg_max_ms)) step = 64'(cfg_max_ms);
        total = total + 32'(step);
        if (total > TOTAL_CEILING) total = TOTAL_CEILING;
        res.retries_made = res.retries_made + 1'b1;
        if (!next_draw_fails()) begin
          res.succeeded = 1'b1;
          break;
        end
      end
      res.backoff_sum_ms = total[TOTAL_W-1:0];
    end
    res.adaptive_base_ms = backoff_base_ms;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_FAIL_LEVEL:  cfg_fail_level  = data[LEVEL_W-1:0];
      CFG_MAX_RETRIES: cfg_retry_max   = data[RETRY_W-1:0];
      CFG_SEED_VALUE:  lcg_state       = data;
      CFG_MIN_BACKOFF: cfg_min_ms      = data[BACKOFF_W-1:0];
      CFG_MAX_BACKOFF: cfg_max_ms      = data[BACKOFF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input backoff_settings_t s);
    write_reg(CFG_FAIL_LEVEL,  CFG_DATA_W'(s.fail_level));
    write_reg(CFG_MAX_RETRIES, CFG_DATA_W'(s.retry_max));
    write_reg(CFG_SEED_VALUE,  CFG_DATA_W'(s.seed_value));
    write_reg(CFG_MIN_BACKOFF, CFG_DATA_W'(s.min_backoff_ms));
    write_reg(CFG_MAX_BACKOFF, CFG_DATA_W'(s.max_backoff_ms));
    cfg_we_i <= 1'b0;
  endtask

  // Call at a clock edge; returns at the edge where the attempt is accepted.
  task automatic send_attempt(input logic [NOW_W-1:0] now_s);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) feed_steady = !feed_steady;
    gap = feed_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(now_s);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic check_outcome(input logic [OUT_DATA_W-1:0] word);
    attempt_outcome_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch($sformatf("result %h with no attempt pending", word));
      return;
    end
    want = pending_outcomes.pop_front();
    if (word[0] !== want.failed)
      report_mismatch($sformatf("failed: expected %0d, got %0d", want.failed, word[0]));
    if (word[1] !== want.succeeded)
      report_mismatch($sformatf("succeeded: expected %0d, got %0d",
                                want.succeeded, word[1]));
    if (word[5:2] !== want.retries_made)
      report_mismatch($sformatf("retries_made: expected %0d, got %0d",
                                want.retries_made, word[5:2]));
    if (word[25:6] !== want.backoff_sum_ms)
      report_mismatch($sformatf("backoff_sum_ms: expected %0d, got %0d",
                                want.backoff_sum_ms, word[25:6]));
    if (word[41:26] !== want.adaptive_base_ms)
      report_mismatch($sformatf("adaptive_base_ms: expected %0d, got %0d",
                                want.adaptive_base_ms, word[41:26]));
  endtask

  initial begin : result_check
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_outcome(m_axis_tdata);
    end
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 23) == 0) sink_steady = !sink_steady;
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_steady ? 0 : $urandom_range(0, 17);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int                active_setting;
    attempt_outcome_t  outcome;
    backoff_settings_t fresh;
    int unsigned       pick;
    logic [NOW_W-1:0]  wall_s;
    active_setting = 0;
    wall_s         = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (int'(directed_rows[r].setting) != active_setting) begin
        active_setting = int'(directed_rows[r].setting);
        wait_drained(LATENCY_MARGIN);
        apply_settings(directed_settings[active_setting]);
      end
      send_attempt(directed_rows[r].now_sec);
      outcome = predict_attempt(directed_rows[r].now_sec);
      pending_outcomes.push_back(directed_rows[r].known ? directed_rows[r].outcome : outcome);
    end

    for (int phase = 0; phase < int'(RANDOM_PHASES); phase++) begin
      wait_drained(LATENCY_MARGIN);
      pick = $urandom_range(0, 7);
      if (pick == 0)      fresh.fail_level = '0;
      else if (pick == 1) fresh.fail_level = '1;
      else if (pick == 2) fresh.fail_level = LEVEL_W'(1);
      else if (pick < 5)  fresh.fail_level = LEVEL_W'($urandom_range(1, 32767));
      else                fresh.fail_level = LEVEL_W'($urandom_range(16384, 32767));
      fresh.retry_max   = RETRY_W'($urandom_range(0, 15));
      fresh.seed_value  = $urandom;
      pick = $urandom_range(0, 7);
      if (pick == 0)      fresh.min_backoff_ms = '0;
      else if (pick == 1) fresh.min_backoff_ms = '1;
      else if (pick == 2) fresh.min_backoff_ms = BACKOFF_W'(1);
      else                fresh.min_backoff_ms = BACKOFF_W'($urandom_range(1, 2000));
      pick = $urandom_range(0, 7);
      if (pick == 0)      fresh.max_backoff_ms = BACKOFF_W'(1);
      else if (pick == 1) fresh.max_backoff_ms = '1;
      else if (pick == 2) fresh.max_backoff_ms = '0;
      else                fresh.max_backoff_ms = BACKOFF_W'($urandom_range(500, 65535));
      apply_settings(fresh);

      for (int n = 0; n < int'(PHASE_ITEMS); n++) begin
        // hold the result side off long enough for the input to back up
        if (phase == 1 && n == 40) sink_hold = LONG_HOLD;
        // mostly advancing time: dense bursts raise the base, sparse ones lower it
        pick = $urandom_range(0, 99);
        if (pick < 60)      wall_s = wall_s + NOW_W'($urandom_range(0, 2));
        else if (pick < 85) wall_s = wall_s + NOW_W'($urandom_range(3, 40));
        else if (pick < 93) wall_s = wall_s - NOW_W'($urandom_range(0, 20));
        else                wall_s = NOW_W'($urandom);
        send_attempt(wall_s);
        pending_outcomes.push_back(predict_attempt(wall_s));
      end
    end

    wait_drained(LATENCY_MARGIN);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
